// ===== rtl/core/idh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idh_pkg
// Shared types and codes for the indexed deadline min-heap.
// ----------------------------------------------------------------------------
package idh_pkg;

    localparam int IDH_CAPACITY = 64;
    localparam int IDH_NUM_IDS  = 64;
    localparam int IDH_ID_W     = 6;
    localparam int IDH_KEY_W    = 64;
    localparam int IDH_COUNT_W  = 7;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_REKEY  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_SE_RD, S_SE_CAP, S_LAST_RD, S_LAST_ID, S_LAST_KEY, S_RESIFT,
        S_UP_RD, S_UP_ID, S_UP_CMP, S_DN_L, S_DN_LID, S_DN_LKEY, S_DN_R,
        S_DN_RID, S_DN_RKEY, S_DN_MOVE, S_PLACE, S_ROOT, S_ROOT_ID, S_ROOT_KEY,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        C_NONE, C_START, C_SE_RD, C_SE_CAP, C_LAST_RD, C_LAST_ID, C_LAST_KEY,
        C_UP_RD, C_UP_ID, C_UP_MOVE, C_DN_L_RD, C_DN_L_ID, C_DN_L_KEY,
        C_DN_R_RD, C_DN_R_ID, C_DN_R_KEY, C_DN_MOVE, C_PLACE, C_ROOT_RD,
        C_ROOT_ID, C_ROOT_KEY, C_ROOT_EMPTY, C_OUT_LOAD
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic in_ready;
    } t_ctl;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_mode;
        logic       in_present;
        logic       full;
        logic       op_remove;
        logic       pos_zero;
        logic       par_zero;
        logic       se_is_last;
        logic       up_less;
        logic       moved;
        logic       has_l;
        logic       has_r;
        logic       take;
        logic       size_zero;
        logic       out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/idh_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idh_in_if
// Operation channel: mode, entry identifier and key.
// ----------------------------------------------------------------------------
interface idh_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [5:0]  entry_id;
    logic [63:0] key;

    modport source (output valid, mode, entry_id, key, input ready);
    modport sink   (input valid, mode, entry_id, key, output ready);
endinterface

// ===== rtl/core/idh_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idh_out_if
// Result channel: status, current minimum and entry count.
// ----------------------------------------------------------------------------
interface idh_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        min_valid;
    logic [5:0]  min_id;
    logic [63:0] min_key;
    logic [6:0]  entry_count;

    modport source (output valid, status, min_valid, min_id, min_key, entry_count,
                    input ready);
    modport sink   (input valid, status, min_valid, min_id, min_key, entry_count,
                    output ready);
endinterface

// ===== rtl/core/idh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/idh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idh_ctrl
// Sequencer for insert, remove and rekey: sift up, sift down, root fetch.
// ----------------------------------------------------------------------------
module idh_ctrl
    import idh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_ctl     o_ctl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_ctl.cmd      = C_NONE;
        o_ctl.in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_ctl.cmd = C_START;
                    n_state   = S_ROOT;
                    if (i_stat.in_mode == MODE_INSERT) begin
                        if (!i_stat.in_present && !i_stat.full) n_state = S_RESIFT;
                    end else if (i_stat.in_mode == MODE_REMOVE ||
                                 i_stat.in_mode == MODE_REKEY) begin
                        if (i_stat.in_present) n_state = S_SE_RD;
                    end
                end
            end
            S_SE_RD: begin
                o_ctl.cmd = C_SE_RD;
                n_state   = S_SE_CAP;
            end
            S_SE_CAP: begin
                o_ctl.cmd = C_SE_CAP;
                if (!i_stat.op_remove) n_state = S_RESIFT;
                else if (i_stat.se_is_last) n_state = S_ROOT;
                else n_state = S_LAST_RD;
            end
            S_LAST_RD: begin
                o_ctl.cmd = C_LAST_RD;
                n_state   = S_LAST_ID;
            end
            S_LAST_ID: begin
                o_ctl.cmd = C_LAST_ID;
                n_state   = S_LAST_KEY;
            end
            S_LAST_KEY: begin
                o_ctl.cmd = C_LAST_KEY;
                n_state   = S_RESIFT;
            end
            S_RESIFT: begin
                n_state = i_stat.pos_zero ? S_DN_L : S_UP_RD;
            end
            S_UP_RD: begin
                o_ctl.cmd = C_UP_RD;
                n_state   = S_UP_ID;
            end
            S_UP_ID: begin
                o_ctl.cmd = C_UP_ID;
                n_state   = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (i_stat.up_less) begin
                    o_ctl.cmd = C_UP_MOVE;
                    n_state   = i_stat.par_zero ? S_PLACE : S_UP_RD;
                end else begin
                    n_state = i_stat.moved ? S_PLACE : S_DN_L;
                end
            end
            S_DN_L: begin
                if (i_stat.has_l) begin
                    o_ctl.cmd = C_DN_L_RD;
                    n_state   = S_DN_LID;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DN_LID: begin
                o_ctl.cmd = C_DN_L_ID;
                n_state   = S_DN_LKEY;
            end
            S_DN_LKEY: begin
                o_ctl.cmd = C_DN_L_KEY;
                n_state   = S_DN_R;
            end
            S_DN_R: begin
                if (i_stat.has_r) begin
                    o_ctl.cmd = C_DN_R_RD;
                    n_state   = S_DN_RID;
                end else begin
                    n_state = i_stat.take ? S_DN_MOVE : S_PLACE;
                end
            end
            S_DN_RID: begin
                o_ctl.cmd = C_DN_R_ID;
                n_state   = S_DN_RKEY;
            end
            S_DN_RKEY: begin
                o_ctl.cmd = C_DN_R_KEY;
                n_state   = S_DN_R;
            end
            S_DN_MOVE: begin
                o_ctl.cmd = C_DN_MOVE;
                n_state   = S_DN_L;
            end
            S_PLACE: begin
                o_ctl.cmd = C_PLACE;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                if (i_stat.size_zero) begin
                    o_ctl.cmd = C_ROOT_EMPTY;
                    n_state   = S_DONE;
                end else begin
                    o_ctl.cmd = C_ROOT_RD;
                    n_state   = S_ROOT_ID;
                end
            end
            S_ROOT_ID: begin
                o_ctl.cmd = C_ROOT_ID;
                n_state   = S_ROOT_KEY;
            end
            S_ROOT_KEY: begin
                o_ctl.cmd = C_ROOT_KEY;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctl.cmd = C_OUT_LOAD;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/core/idh_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idh_dpath
// Heap, key and slot memories, moving-entry registers and result register.
// ----------------------------------------------------------------------------
module idh_dpath
    import idh_pkg::*;
#(
    parameter int CAPACITY = IDH_CAPACITY
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctl  i_ctl,
    output t_dp_stat o_stat,
    idh_in_if.sink    i_in,
    idh_out_if.source o_out
);
    localparam int LIMIT = (CAPACITY < IDH_NUM_IDS) ? CAPACITY : IDH_NUM_IDS;
    localparam int POS_W = $clog2(LIMIT);
    localparam int CNT_W = POS_W + 1;
    localparam int IDX_W = POS_W + 2;

    logic [IDH_NUM_IDS-1:0] r_valid;
    logic [CNT_W-1:0]       r_size;
    logic [1:0]             r_mode;
    logic [IDH_ID_W-1:0]    r_id;
    logic [IDH_KEY_W-1:0]   r_key;
    logic [POS_W-1:0]       r_pos;
    logic                   r_moved;
    logic [IDH_ID_W-1:0]    r_cid;
    logic                   r_take;
    logic                   r_rdone;
    logic [POS_W-1:0]       r_best_pos;
    logic [IDH_ID_W-1:0]    r_best_id;
    logic [IDH_KEY_W-1:0]   r_best_key;
    logic [1:0]             r_status;
    logic [IDH_ID_W-1:0]    r_min_id;
    logic [IDH_KEY_W-1:0]   r_min_key;
    logic                   r_out_valid;
    logic [1:0]             r_out_status;
    logic                   r_out_min_valid;
    logic [IDH_ID_W-1:0]    r_out_min_id;
    logic [IDH_KEY_W-1:0]   r_out_min_key;
    logic [IDH_COUNT_W-1:0] r_out_count;

    logic                 hs_we, ek_we, se_we;
    logic [POS_W-1:0]     hs_waddr, hs_raddr;
    logic [IDH_ID_W-1:0]  hs_wdata, hs_rdata;
    logic [IDH_ID_W-1:0]  ek_waddr, ek_raddr;
    logic [IDH_KEY_W-1:0] ek_wdata, ek_rdata;
    logic [IDH_ID_W-1:0]  se_waddr, se_raddr;
    logic [POS_W-1:0]     se_wdata, se_rdata;

    logic [IDX_W-1:0] l_idx, r_idx;
    logic [POS_W-1:0] parent;
    logic             in_present, full, ins_ok, rekey_ok, rm_ok;

    assign l_idx  = {1'b0, r_pos, 1'b1};
    assign r_idx  = l_idx + IDX_W'(1);
    assign parent = (r_pos - POS_W'(1)) >> 1;

    assign in_present = r_valid[i_in.entry_id];
    assign full       = (r_size >= CNT_W'(LIMIT));
    assign ins_ok     = (i_in.mode == MODE_INSERT) && !in_present && !full;
    assign rekey_ok   = (i_in.mode == MODE_REKEY) && in_present;
    assign rm_ok      = (i_in.mode == MODE_REMOVE) && in_present;

    always_comb begin
        hs_raddr = '0;
        case (i_ctl.cmd)
            C_LAST_RD: hs_raddr = r_size[POS_W-1:0];
            C_UP_RD:   hs_raddr = parent;
            C_DN_L_RD: hs_raddr = l_idx[POS_W-1:0];
            C_DN_R_RD: hs_raddr = r_idx[POS_W-1:0];
            default:   hs_raddr = '0;
        endcase
    end

    assign ek_raddr = hs_rdata;
    assign se_raddr = r_id;

    always_comb begin
        hs_we    = 1'b0;
        se_we    = 1'b0;
        hs_waddr = r_pos;
        hs_wdata = r_id;
        se_waddr = r_id;
        se_wdata = r_pos;
        case (i_ctl.cmd)
            C_UP_MOVE: begin
                hs_we    = 1'b1;
                se_we    = 1'b1;
                hs_wdata = r_cid;
                se_waddr = r_cid;
            end
            C_DN_MOVE: begin
                hs_we    = 1'b1;
                se_we    = 1'b1;
                hs_wdata = r_best_id;
                se_waddr = r_best_id;
            end
            C_PLACE: begin
                hs_we = 1'b1;
                se_we = 1'b1;
            end
            default: begin
                hs_we = 1'b0;
            end
        endcase
    end

    assign ek_we    = (i_ctl.cmd == C_START) && (ins_ok || rekey_ok);
    assign ek_waddr = i_in.entry_id;
    assign ek_wdata = i_in.key;

    idh_ram #(.WIDTH(IDH_ID_W), .DEPTH(LIMIT)) u_hs (
        .i_clk(i_clk), .i_we(hs_we), .i_waddr(hs_waddr), .i_wdata(hs_wdata),
        .i_raddr(hs_raddr), .o_rdata(hs_rdata)
    );
    idh_ram #(.WIDTH(IDH_KEY_W), .DEPTH(IDH_NUM_IDS)) u_ek (
        .i_clk(i_clk), .i_we(ek_we), .i_waddr(ek_waddr), .i_wdata(ek_wdata),
        .i_raddr(ek_raddr), .o_rdata(ek_rdata)
    );
    idh_ram #(.WIDTH(POS_W), .DEPTH(IDH_NUM_IDS)) u_se (
        .i_clk(i_clk), .i_we(se_we), .i_waddr(se_waddr), .i_wdata(se_wdata),
        .i_raddr(se_raddr), .o_rdata(se_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.cmd == C_OUT_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctl.cmd)
                C_START: begin
                    if (ins_ok) begin
                        r_valid[i_in.entry_id] <= 1'b1;
                        r_size                 <= r_size + CNT_W'(1);
                    end else if (rm_ok) begin
                        r_valid[i_in.entry_id] <= 1'b0;
                        r_size                 <= r_size - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            C_START: begin
                r_mode  <= i_in.mode;
                r_id    <= i_in.entry_id;
                r_key   <= i_in.key;
                r_pos   <= r_size[POS_W-1:0];
                r_moved <= 1'b0;
                if (i_in.mode == MODE_INSERT) begin
                    r_status <= in_present ? ST_PRESENT : (full ? ST_FULL : ST_DONE);
                end else if (i_in.mode == MODE_REMOVE || i_in.mode == MODE_REKEY) begin
                    r_status <= in_present ? ST_DONE : ST_ABSENT;
                end else begin
                    r_status <= ST_DONE;
                end
            end
            C_SE_CAP:   r_pos <= se_rdata;
            C_LAST_ID:  r_id  <= hs_rdata;
            C_LAST_KEY: r_key <= ek_rdata;
            C_UP_ID:    r_cid <= hs_rdata;
            C_UP_MOVE: begin
                r_pos   <= parent;
                r_moved <= 1'b1;
            end
            C_DN_L_RD: begin
                r_take     <= 1'b0;
                r_best_key <= r_key;
            end
            C_DN_L_ID:  r_cid <= hs_rdata;
            C_DN_R_ID:  r_cid <= hs_rdata;
            C_DN_L_KEY: begin
                if (ek_rdata < r_key) begin
                    r_take     <= 1'b1;
                    r_best_pos <= l_idx[POS_W-1:0];
                    r_best_id  <= r_cid;
                    r_best_key <= ek_rdata;
                end
            end
            C_DN_R_KEY: begin
                if (ek_rdata < r_best_key) begin
                    r_take     <= 1'b1;
                    r_best_pos <= r_idx[POS_W-1:0];
                    r_best_id  <= r_cid;
                    r_best_key <= ek_rdata;
                end
            end
            C_DN_MOVE:    r_pos <= r_best_pos;
            C_ROOT_ID:    r_min_id  <= hs_rdata;
            C_ROOT_KEY:   r_min_key <= ek_rdata;
            C_ROOT_EMPTY: begin
                r_min_id  <= '0;
                r_min_key <= '0;
            end
            C_OUT_LOAD: begin
                r_out_status    <= r_status;
                r_out_min_valid <= (r_size != '0);
                r_out_min_id    <= r_min_id;
                r_out_min_key   <= r_min_key;
                r_out_count     <= IDH_COUNT_W'(r_size);
            end
            default: begin
            end
        endcase
    end

    // has_r is sampled in S_DN_R both before and after the right-child fetch;
    // r_rdone keeps the second visit from refetching
    assign o_stat.in_valid   = i_in.valid;
    assign o_stat.in_mode    = i_in.mode;
    assign o_stat.in_present = in_present;
    assign o_stat.full       = full;
    assign o_stat.op_remove  = (r_mode == MODE_REMOVE);
    assign o_stat.pos_zero   = (r_pos == '0);
    assign o_stat.par_zero   = (parent == '0);
    assign o_stat.se_is_last = ({1'b0, se_rdata} == r_size);
    assign o_stat.up_less    = (r_key < ek_rdata);
    assign o_stat.moved      = r_moved;
    assign o_stat.has_l      = (l_idx < IDX_W'(r_size));
    assign o_stat.has_r      = (r_idx < IDX_W'(r_size)) && !r_rdone;
    assign o_stat.take       = r_take;
    assign o_stat.size_zero  = (r_size == '0);
    assign o_stat.out_free   = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdone <= 1'b0;
        end else if (i_ctl.cmd == C_DN_R_RD) begin
            r_rdone <= 1'b1;
        end else if (i_ctl.cmd == C_DN_L_RD) begin
            r_rdone <= 1'b0;
        end
    end

    assign i_in.ready        = i_ctl.in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.min_valid   = r_out_min_valid;
    assign o_out.min_id      = r_out_min_id;
    assign o_out.min_key     = r_out_min_key;
    assign o_out.entry_count = r_out_count;

`ifndef NO_ASSERTIONS
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= CNT_W'(LIMIT))
        else $error("heap size above limit");
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_size))
        else $error("valid bits disagree with heap size");
    a_up_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.cmd == C_UP_MOVE |-> r_pos != '0)
        else $error("sift-up from root");
    a_min_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_min_valid == (r_out_count != '0)))
        else $error("min_valid disagrees with entry count");
`endif
endmodule

// ===== rtl/core/indexed_deadline_min_heap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_deadline_min_heap
// Indexed binary min-heap of 6-bit entry ids keyed by 64-bit deadlines.
//
//  channel  dir  fields
//  i_in     in   mode, entry_id, key
//  o_out    out  status, min_valid, min_id, min_key, entry_count
//
// One word at a time. A word that changes nothing goes straight to the root
// fetch. Before placement an entry may sift up, one parent compare per level,
// or sift down (one heap-slot RAM read, then one key RAM read per child);
// remove and rekey first look up the slot; remove may also fetch the last entry.
// Synchronous active-low reset empties the heap at once; no clearing pass.
// A result waiting in the output register does not block the next word;
// only the following result waits for it.
// ----------------------------------------------------------------------------
module indexed_deadline_min_heap
    import idh_pkg::*;
#(
    parameter int CAPACITY = IDH_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    idh_in_if.sink    i_in,
    idh_out_if.source o_out
);
    t_ctl     ctl;
    t_dp_stat stat;

    idh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_stat(stat), .o_ctl(ctl)
    );

    idh_dpath #(.CAPACITY(CAPACITY)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_stat(stat),
        .i_in(i_in), .o_out(o_out)
    );
endmodule
